// ===== hw/rtl/level_table_with_priority_eviction_macros.svh =====
// Assertion helpers used by the level table RTL.
`ifndef LEVEL_TABLE_WITH_PRIORITY_EVICTION_MACROS_SVH
`define LEVEL_TABLE_WITH_PRIORITY_EVICTION_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LVTB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication outside reset.
`define LVTB_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lvtb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lvtb_pkg;

  localparam int ID_W       = 32;
  localparam int PRICE_W    = 32;
  localparam int TS_W       = 48;
  localparam int LVL_W      = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 5;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_TRIGGER = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVELS = CFG_IDX_W'(1);

  localparam logic [CFG_DATA_W-1:0] MAX_LEVELS_RST = CFG_DATA_W'(16);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  // one slot as held in the table memory
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRICE_W-1:0] price;
    logic [TS_W-1:0]    created;
    logic               trig;
  } entry_t;

  // summary of one pass over the table
  typedef struct packed {
    logic found;     // a valid slot holds the key id
    logic any;       // at least one valid slot
    logic has_free;  // at least one empty slot
    logic has_trig;  // at least one valid triggered slot
  } scan_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lvtb_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lvtb_scan
  import lvtb_pkg::*;
#(
  parameter int CAPACITY = 16,
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               clear,
  input  wire logic               ent_vld,
  input  wire logic [IDX_W-1:0]   ent_idx,
  input  wire logic               ent_valid,
  input  wire entry_t             ent,
  input  wire logic [ID_W-1:0]    key_id,
  input  wire logic [PRICE_W-1:0] mid,
  output scan_flags_t             flags,
  output logic [IDX_W-1:0]        match_idx,
  output logic [PRICE_W-1:0]      match_price,
  output logic [TS_W-1:0]         match_created,
  output logic [IDX_W-1:0]        victim_idx,
  output logic [ID_W-1:0]         victim_id,
  output logic [IDX_W-1:0]        free_idx
);

  scan_flags_t        flags_r, flags_nxt;
  logic [IDX_W-1:0]   match_idx_r;
  logic [PRICE_W-1:0] match_price_r;
  logic [TS_W-1:0]    match_ts_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic [IDX_W-1:0]   trig_idx_r;
  logic [ID_W-1:0]    trig_id_r;
  logic [IDX_W-1:0]   far_idx_r;
  logic [ID_W-1:0]    far_id_r;
  logic [PRICE_W-1:0] far_d_r;
  logic [IDX_W-1:0]   old_idx_r;
  logic [ID_W-1:0]    old_id_r;
  logic [TS_W-1:0]    old_ts_r;

  logic               hit;
  logic               take_match, take_free, take_trig, take_far, take_old;
  logic [PRICE_W-1:0] span;

  assign hit  = ent_vld && ent_valid;
  assign span = (ent.price >= mid) ? (ent.price - mid) : (mid - ent.price);

  assign take_match = hit && (ent.id == key_id) && !flags_r.found;
  assign take_free  = ent_vld && !ent_valid && !flags_r.has_free;
  assign take_trig  = hit && ent.trig && (!flags_r.has_trig || (ent.id < trig_id_r));
  // lower id wins exact ties (distance here, age below); ids of valid slots are distinct
  assign take_far   = hit && (!flags_r.any || (span > far_d_r) ||
                              ((span == far_d_r) && (ent.id < far_id_r)));
  assign take_old   = hit && (!flags_r.any || (ent.created < old_ts_r) ||
                              ((ent.created == old_ts_r) && (ent.id < old_id_r)));

  always_comb begin
    flags_nxt = flags_r;
    if (clear) begin
      flags_nxt = '0;
    end else begin
      if (take_match) flags_nxt.found    = 1'b1;
      if (take_free)  flags_nxt.has_free = 1'b1;
      if (take_trig)  flags_nxt.has_trig = 1'b1;
      if (hit)        flags_nxt.any      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_match) begin
      match_idx_r   <= ent_idx;
      match_price_r <= ent.price;
      match_ts_r    <= ent.created;
    end
    if (take_free) free_idx_r <= ent_idx;
    if (take_trig) begin
      trig_idx_r <= ent_idx;
      trig_id_r  <= ent.id;
    end
    if (take_far) begin
      far_idx_r <= ent_idx;
      far_id_r  <= ent.id;
      far_d_r   <= span;
    end
    if (take_old) begin
      old_idx_r <= ent_idx;
      old_id_r  <= ent.id;
      old_ts_r  <= ent.created;
    end
  end

  always_comb begin
    if (flags_r.has_trig) begin
      victim_idx = trig_idx_r;
      victim_id  = trig_id_r;
    end else if (mid != '0) begin
      victim_idx = far_idx_r;
      victim_id  = far_id_r;
    end else begin
      victim_idx = old_idx_r;
      victim_id  = old_id_r;
    end
  end

  assign flags         = flags_r;
  assign match_idx     = match_idx_r;
  assign match_price   = match_price_r;
  assign match_created = match_ts_r;
  assign free_idx      = free_idx_r;

endmodule

`default_nettype wire

// ===== hw/rtl/level_table_with_priority_eviction.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "level_table_with_priority_eviction_macros.svh"

// Channel  Handshake                    Payload
// in       start, busy                  in_operation, in_level_id, in_price,
//                                       in_timestamp, in_mid_price
// out      out_valid (one-cycle strobe) out_evicted, out_evicted_id, out_stored,
//                                       out_found, out_level_count
// cfg      cfg_valid, cfg_ready         cfg_index, cfg_data
//
// An item is accepted in IDLE; SCAN reads the slot memory one slot per cycle over all
// CAPACITY slots, DRAIN takes the last read data and COMMIT does the write-back.
// The result strobes in the cycle after the write-back.
// Synchronous reset clears the slot valid bits, the count and the registers to
// enabled=1, max_levels=16; the slot memory itself needs no clearing pass.
// Results cannot be held off; a new item may start while a result is shown.

module level_table_with_priority_eviction
  import lvtb_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_operation,
  input  wire logic [ID_W-1:0]       in_level_id,
  input  wire logic [PRICE_W-1:0]    in_price,
  input  wire logic [TS_W-1:0]       in_timestamp,
  input  wire logic [PRICE_W-1:0]    in_mid_price,
  output logic                       out_valid,
  output logic                       out_evicted,
  output logic [ID_W-1:0]            out_evicted_id,
  output logic                       out_stored,
  output logic                       out_found,
  output logic [LVL_W-1:0]           out_level_count,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int LIM_W = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  state_t state_r, state_nxt;

  logic                  enabled_r;
  logic [CFG_DATA_W-1:0] max_levels_r;

  logic                  op_r;
  logic [ID_W-1:0]       id_r;
  logic [PRICE_W-1:0]    price_r;
  logic [TS_W-1:0]       ts_r;
  logic [PRICE_W-1:0]    mid_r;

  logic [CAPACITY-1:0]   valid_r, valid_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;

  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                  proc_vld_r;
  logic [IDX_W-1:0]      proc_idx_r;

  entry_t                mem [CAPACITY];
  entry_t                rdata_r;
  logic                  rd_en;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  entry_t                wr_data;

  logic                  out_valid_r;
  logic                  out_evicted_r;
  logic [ID_W-1:0]       out_evicted_id_r;
  logic                  out_stored_r;
  logic                  out_found_r;
  logic [LVL_W-1:0]      out_level_count_r;

  logic                  accept;
  logic                  commit;

  scan_flags_t           flags;
  logic [IDX_W-1:0]      match_idx;
  logic [PRICE_W-1:0]    match_price;
  logic [TS_W-1:0]       match_created;
  logic [IDX_W-1:0]      victim_idx;
  logic [ID_W-1:0]       victim_id;
  logic [IDX_W-1:0]      free_idx;

  logic [LIM_W-1:0]      limit;
  logic [LIM_W-1:0]      count_ext;
  logic                  do_evict;
  logic                  do_store;
  logic                  do_found;
  logic                  match_alive;
  logic [IDX_W-1:0]      slot_idx;
  logic                  slot_ok;

  assign accept    = start && (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r    <= 1'b1;
      max_levels_r <= MAX_LEVELS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLED:    enabled_r    <= cfg_data[0];
        REG_MAX_LEVELS: max_levels_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_SCAN;
      ST_SCAN:   if (rd_idx_r == LAST_IDX) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state_r != ST_IDLE);
    rd_en      = (state_r == ST_SCAN);
    commit     = (state_r == ST_COMMIT);
    rd_idx_nxt = rd_idx_r;
    if (state_r == ST_IDLE) begin
      rd_idx_nxt = '0;
    end else if (rd_en && (rd_idx_r != LAST_IDX)) begin
      rd_idx_nxt = rd_idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rd_idx_r   <= '0;
      proc_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_idx_r   <= rd_idx_nxt;
      proc_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    proc_idx_r <= rd_idx_r;
    if (accept) begin
      op_r    <= in_operation;
      id_r    <= in_level_id;
      price_r <= in_price;
      ts_r    <= in_timestamp;
      mid_r   <= in_mid_price;
    end
  end

  // ---------------- slot memory ----------------
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_idx_r];
  end

  lvtb_scan #(
    .CAPACITY (CAPACITY)
  ) u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .clear         (accept),
    .ent_vld       (proc_vld_r),
    .ent_idx       (proc_idx_r),
    .ent_valid     (valid_r[proc_idx_r]),
    .ent           (rdata_r),
    .key_id        (id_r),
    .mid           (mid_r),
    .flags         (flags),
    .match_idx     (match_idx),
    .match_price   (match_price),
    .match_created (match_created),
    .victim_idx    (victim_idx),
    .victim_id     (victim_id),
    .free_idx      (free_idx)
  );

  // ---------------- write-back decision ----------------
  assign limit = (LIM_W'(max_levels_r) > LIM_W'(CAPACITY)) ? LIM_W'(CAPACITY)
                                                         : LIM_W'(max_levels_r);
  assign count_ext = LIM_W'(count_r);

  always_comb begin
    do_evict    = commit && (op_r == OP_INSERT) && enabled_r &&
                  (count_ext >= limit) && flags.any;
    // an evicted match no longer exists for the store that follows
    match_alive = flags.found && !(do_evict && (victim_idx == match_idx));
    if (do_evict) begin
      slot_ok  = 1'b1;
      slot_idx = (flags.has_free && (free_idx < victim_idx)) ? free_idx : victim_idx;
    end else begin
      slot_ok  = flags.has_free;
      slot_idx = free_idx;
    end
    if (match_alive) begin
      slot_ok  = 1'b1;
      slot_idx = match_idx;
    end
    do_store = commit && (op_r == OP_INSERT) && enabled_r && (id_r != '0) && slot_ok;
    do_found = commit && (op_r == OP_TRIGGER) && flags.found;

    wr_en   = do_store || do_found;
    wr_idx  = do_found ? match_idx : slot_idx;
    wr_data = do_found ?
              entry_t'{id: id_r, price: match_price, created: match_created, trig: 1'b1} :
              entry_t'{id: id_r, price: price_r, created: ts_r, trig: 1'b0};

    valid_nxt = valid_r;
    if (do_evict) valid_nxt[victim_idx] = 1'b0;
    if (do_store) valid_nxt[slot_idx]   = 1'b1;

    count_nxt = count_r - CNT_W'(do_evict) + CNT_W'(do_store && !match_alive);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= commit;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_evicted_r     <= do_evict;
      out_evicted_id_r  <= do_evict ? victim_id : '0;
      out_stored_r      <= do_store;
      out_found_r       <= do_found;
      out_level_count_r <= LVL_W'(LIM_W'(count_nxt));
    end
  end

  assign out_valid       = out_valid_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_id  = out_evicted_id_r;
  assign out_stored      = out_stored_r;
  assign out_found       = out_found_r;
  assign out_level_count = out_level_count_r;

  // ---------------- assertions ----------------
  `LVTB_ASSERT(a_count_matches_valid, clk, rst_n, count_r == CNT_W'($countones(valid_r)), "count out of step with valid bits")
  `LVTB_IMPLY(a_result_after_commit, clk, rst_n, out_valid_r, $past(state_r == ST_COMMIT), "result strobe without write-back")
  `LVTB_IMPLY(a_found_excl_stored, clk, rst_n, out_valid_r, !(out_found_r && out_stored_r), "trigger and insert outcome together")
  `LVTB_IMPLY(a_no_write_in_scan, clk, rst_n, rd_en, !wr_en, "memory write during scan")

endmodule

`default_nettype wire
